// ----- sv/pcri_pkg.sv -----
package pcri_pkg;

   // Field widths fixed by the item layout.
   localparam int LEN_W        = 14;
   localparam int WORD_W       = 16;
   localparam int RING_FIELD_W = 19;
   localparam int OFS_FIELD_W  = 28;
   localparam int COUNT_W      = 32;
   localparam int BYTES_LOW_W  = 30;
   localparam int BYTES_HIGH_W = 16;
   localparam int RATE_W       = 35;

   localparam int CSR_DATA_W   = 28;
   localparam int CSR_INDEX_W  = 3;

   localparam int REQ_DATA_W   = 112;
   localparam int RSP_DATA_W   = 256;
   localparam int RSP_PAD_W    = 6;

   // Bytes of Ethernet header that the length field leaves out, and the extra
   // bytes a ring entry stores in front of the frame.
   localparam logic [LEN_W-1:0] HEADER_BYTES = 14'd14;
   localparam logic [LEN_W-1:0] ENTRY_EXTRA  = 14'd12;

   localparam logic [BYTES_LOW_W-1:0] ONE_BILLION = 30'd1000000000;

   localparam logic [WORD_W-1:0] FLAG_MISSING   = 16'h8000;
   localparam logic [WORD_W-1:0] FLAG_END_EVENT = 16'h4000;
   localparam logic [WORD_W-1:0] TRAILER_MARK   = 16'h8000;
   localparam logic [WORD_W-1:0] TRAILER_ALL    = 16'hFFFF;
   localparam logic [WORD_W-1:0] MARKER_MASK_A  = 16'hEF00;
   localparam logic [WORD_W-1:0] MARKER_MASK_B  = 16'hAF00;

   localparam logic [CSR_DATA_W-1:0]   BUFFER_LIMIT_RESET = 28'd200694820;
   localparam logic [CSR_DATA_W-1:0]   EVENT_LIMIT_RESET  = 28'd200000000;
   localparam logic [RING_FIELD_W-1:0] RING_ENTRIES_RESET = 19'd511986;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CHECK_MISSING      = 3'd0,
      CSR_CHECK_END_EVENT    = 3'd1,
      CSR_RATE_ENABLE        = 3'd2,
      CSR_BUFFER_LIMIT       = 3'd3,
      CSR_EVENT_BUFFER_LIMIT = 3'd4,
      CSR_RING_ENTRIES       = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [LEN_W-1:0]  frame_length;
      logic [WORD_W-1:0] sequence_counter;
      logic [WORD_W-1:0] trailer_word_a;
      logic [WORD_W-1:0] trailer_word_b;
      logic [WORD_W-1:0] trailer_word_c;
      logic [WORD_W-1:0] trailer_word_d;
      logic [WORD_W-1:0] marker_word;
      logic              second_boundary;
   } req_item_type;

   // Receive statistics after the current item has been counted.
   typedef struct packed {
      logic [COUNT_W-1:0]      frame_count;
      logic [BYTES_LOW_W-1:0]  byte_count_low;
      logic [BYTES_HIGH_W-1:0] byte_count_high;
      logic [RATE_W-1:0]       rate_bits;
   } stats_type;

endpackage

// ----- sv/pcri_stats.sv -----
module pcri_stats
   import pcri_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [LEN_W-1:0] frame_length,
   input  logic             second_boundary,
   input  logic             rate_enable,
   output stats_type        stats_next
);

   logic [COUNT_W-1:0]      frames_seen_ff, frames_seen_in;
   logic [BYTES_LOW_W-1:0]  bytes_low_ff, bytes_low_in;
   logic [BYTES_HIGH_W-1:0] bytes_high_ff, bytes_high_in;
   logic [COUNT_W-1:0]      second_sum_ff, second_sum_in;
   logic [RATE_W-1:0]       rate_value_ff, rate_value_in;
   logic                    rate_latched_ff, rate_latched_in;

   logic [LEN_W:0]          wire_bytes;
   logic [BYTES_LOW_W:0]    bytes_sum;
   logic [COUNT_W-1:0]      sum_added;

   always_comb begin
      wire_bytes     = {1'b0, frame_length} + {1'b0, HEADER_BYTES};
      frames_seen_in = frames_seen_ff + COUNT_W'(1);

      // The low count may settle at exactly one billion; only a sum above it
      // carries into the high count.
      bytes_sum = {1'b0, bytes_low_ff} + (BYTES_LOW_W + 1)'(wire_bytes);
      if (bytes_sum > {1'b0, ONE_BILLION}) begin
         bytes_low_in  = BYTES_LOW_W'(bytes_sum - {1'b0, ONE_BILLION});
         bytes_high_in = bytes_high_ff + BYTES_HIGH_W'(1);
      end else begin
         bytes_low_in  = bytes_sum[BYTES_LOW_W-1:0];
         bytes_high_in = bytes_high_ff;
      end

      sum_added       = second_sum_ff + COUNT_W'(wire_bytes);
      second_sum_in   = second_sum_ff;
      rate_value_in   = rate_value_ff;
      rate_latched_in = rate_latched_ff;
      if (rate_enable) begin
         second_sum_in = sum_added;
         if (!second_boundary) begin
            rate_latched_in = 1'b0;
         end else if (!rate_latched_ff) begin
            rate_value_in   = {sum_added, 3'b000};
            second_sum_in   = '0;
            rate_latched_in = 1'b1;
         end
      end

      stats_next.frame_count     = frames_seen_in;
      stats_next.byte_count_low  = bytes_low_in;
      stats_next.byte_count_high = bytes_high_in;
      stats_next.rate_bits       = rate_value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_seen_ff  <= '0;
         bytes_low_ff    <= '0;
         bytes_high_ff   <= '0;
         second_sum_ff   <= '0;
         rate_value_ff   <= '0;
         rate_latched_ff <= 1'b0;
      end else if (step) begin
         frames_seen_ff  <= frames_seen_in;
         bytes_low_ff    <= bytes_low_in;
         bytes_high_ff   <= bytes_high_in;
         second_sum_ff   <= second_sum_in;
         rate_value_ff   <= rate_value_in;
         rate_latched_ff <= rate_latched_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_bytes_low_bounded: assert property (@(posedge clock) disable iff (reset)
      bytes_low_ff <= ONE_BILLION)
      else $error("byte count low part exceeds one billion");

   a_latch_clears_sum: assert property (@(posedge clock) disable iff (reset)
      $rose(rate_latched_ff) |-> second_sum_ff == '0)
      else $error("per-second sum not cleared when rate was latched");
`endif

endmodule

// ----- sv/packet_capture_ring_indexer_core.sv -----
// Ring indexer for a frame capture buffer. Each request item describes one
// received frame; the core assigns it a data-buffer offset and a descriptor
// ring entry, flags sequence gaps and end-of-event trailers, and returns one
// response item holding the placement plus running receive statistics. An
// accepted item is held in an input register, is evaluated against the
// current state by short logic that also updates the state, and is written
// to the response register, which drives rsp_tvalid and the result. The
// core sustains one item per clock while the response is taken; the two
// stages stall together while the response is not taken.
// There is no clearing pass after reset. Configuration is written through
// the csr_ port; the user must write it only while no item is in flight, as
// the block itself does not enforce this.
module packet_capture_ring_indexer_core
   import pcri_pkg::*;
#(
   parameter int OFFSET_BITS     = 28,
   parameter int RING_INDEX_BITS = 19
)
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   // frame_length[13:0], sequence_counter[29:14], trailer_word_a[45:30],
   // trailer_word_b[61:46], trailer_word_c[77:62], trailer_word_d[93:78],
   // marker_word[109:94], second_boundary[110], zero fill [111]
   input  logic [REQ_DATA_W-1:0]  req_tdata,

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // ring_index[18:0], entry_flags[34:19], stored_length[48:35],
   // write_offset[76:49], tail_offset[104:77], frame_count[136:105],
   // missing_count[168:137], byte_count_low[198:169],
   // byte_count_high[214:199], rate_bits[249:215], zero fill [255:250]
   output logic [RSP_DATA_W-1:0]  rsp_tdata,

   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Limits are held no wider than both the register field and the state.
   localparam int OFS_LIM_BITS = (OFFSET_BITS < OFS_FIELD_W) ? OFFSET_BITS : OFS_FIELD_W;
   localparam int IDX_LIM_BITS =
      (RING_INDEX_BITS < RING_FIELD_W) ? RING_INDEX_BITS : RING_FIELD_W;

   // Configuration registers.
   logic                    check_missing_ff;
   logic                    check_end_event_ff;
   logic                    rate_enable_ff;
   logic [OFS_LIM_BITS-1:0] buffer_limit_ff;
   logic [OFS_LIM_BITS-1:0] event_limit_ff;
   logic [IDX_LIM_BITS-1:0] ring_entries_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         check_missing_ff   <= 1'b1;
         check_end_event_ff <= 1'b1;
         rate_enable_ff     <= 1'b1;
         buffer_limit_ff    <= OFS_LIM_BITS'(BUFFER_LIMIT_RESET);
         event_limit_ff     <= OFS_LIM_BITS'(EVENT_LIMIT_RESET);
         ring_entries_ff    <= IDX_LIM_BITS'(RING_ENTRIES_RESET);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CHECK_MISSING:      check_missing_ff   <= csr_wdata[0];
            CSR_CHECK_END_EVENT:    check_end_event_ff <= csr_wdata[0];
            CSR_RATE_ENABLE:        rate_enable_ff     <= csr_wdata[0];
            CSR_BUFFER_LIMIT:       buffer_limit_ff    <= csr_wdata[OFS_LIM_BITS-1:0];
            CSR_EVENT_BUFFER_LIMIT: event_limit_ff     <= csr_wdata[OFS_LIM_BITS-1:0];
            CSR_RING_ENTRIES:       ring_entries_ff    <= csr_wdata[IDX_LIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Input register. It refills in the same cycle that its item moves on.
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   req_item_type req_item;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         advance;

   assign req_item.frame_length     = req_tdata[13:0];
   assign req_item.sequence_counter = req_tdata[29:14];
   assign req_item.trailer_word_a   = req_tdata[45:30];
   assign req_item.trailer_word_b   = req_tdata[61:46];
   assign req_item.trailer_word_c   = req_tdata[77:62];
   assign req_item.trailer_word_d   = req_tdata[93:78];
   assign req_item.marker_word      = req_tdata[109:94];
   assign req_item.second_boundary  = req_tdata[110];

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= req_item;
      end
   end

   // Placement state.
   logic [OFFSET_BITS-1:0]     buffer_offset_ff, buffer_offset_in;
   logic [RING_INDEX_BITS-1:0] ring_position_ff, ring_position_in;
   logic [WORD_W-1:0]          wrap_count_ff, wrap_count_in;
   logic [COUNT_W-1:0]         gaps_seen_ff, gaps_seen_in;
   logic [WORD_W-1:0]          last_sequence_ff, last_sequence_in;

   logic [OFFSET_BITS:0]       next_offset;
   logic [RING_INDEX_BITS:0]   next_index;
   logic [WORD_W-1:0]          expected_sequence;
   logic                       gap;
   logic                       end_event;
   logic                       trailer_match;
   logic                       marker_match;
   logic                       wrap;
   logic [WORD_W-1:0]          entry_flags;
   logic [LEN_W-1:0]           stored_length;
   logic [31:0]                write_wide;
   logic [31:0]                tail_wide;
   logic [23:0]                index_wide;
   stats_type                  stats_next;

   always_comb begin
      // The sequence check is skipped until the ring has moved off its very
      // first entry, so the first frame after reset never counts as a gap.
      expected_sequence = last_sequence_ff + WORD_W'(1);
      gap = check_missing_ff && (expected_sequence != in_item_ff.sequence_counter) &&
            ((ring_position_ff != '0) || (wrap_count_ff != '0));
      gaps_seen_in     = gap ? gaps_seen_ff + COUNT_W'(1) : gaps_seen_ff;
      last_sequence_in = check_missing_ff ? in_item_ff.sequence_counter : last_sequence_ff;

      // End of event: either the fixed four-word trailer or the marker mask.
      trailer_match = (in_item_ff.trailer_word_a == TRAILER_MARK) &&
                      (in_item_ff.trailer_word_b == TRAILER_MARK) &&
                      (in_item_ff.trailer_word_c == TRAILER_ALL) &&
                      (in_item_ff.trailer_word_d == TRAILER_MARK);
      marker_match  = ((in_item_ff.marker_word & MARKER_MASK_A) == MARKER_MASK_A) &&
                      ((in_item_ff.marker_word & MARKER_MASK_B) == MARKER_MASK_B);
      end_event     = check_end_event_ff && (trailer_match || marker_match);

      // The flags carry the wrap count as it stood before this frame.
      entry_flags = wrap_count_ff | (gap ? FLAG_MISSING : '0) |
                    (end_event ? FLAG_END_EVENT : '0);
      stored_length = in_item_ff.frame_length + ENTRY_EXTRA;

      next_offset = {1'b0, buffer_offset_ff} + (OFFSET_BITS + 1)'(in_item_ff.frame_length) +
                    (OFFSET_BITS + 1)'(ENTRY_EXTRA);
      next_index  = {1'b0, ring_position_ff} + (RING_INDEX_BITS + 1)'(1);

      wrap = (next_offset > (OFFSET_BITS + 1)'(buffer_limit_ff)) ||
             (end_event && (next_offset > (OFFSET_BITS + 1)'(event_limit_ff))) ||
             (next_index >= (RING_INDEX_BITS + 1)'(ring_entries_ff));

      if (wrap) begin
         buffer_offset_in = '0;
         ring_position_in = '0;
         wrap_count_in    = wrap_count_ff + WORD_W'(1);
      end else begin
         buffer_offset_in = next_offset[OFFSET_BITS-1:0];
         ring_position_in = next_index[RING_INDEX_BITS-1:0];
         wrap_count_in    = wrap_count_ff;
      end

      write_wide = 32'(buffer_offset_ff);
      tail_wide  = 32'(buffer_offset_in);
      index_wide = 24'(ring_position_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_offset_ff <= '0;
         ring_position_ff <= '0;
         wrap_count_ff    <= '0;
         gaps_seen_ff     <= '0;
         last_sequence_ff <= '0;
      end else if (advance) begin
         buffer_offset_ff <= buffer_offset_in;
         ring_position_ff <= ring_position_in;
         wrap_count_ff    <= wrap_count_in;
         gaps_seen_ff     <= gaps_seen_in;
         last_sequence_ff <= last_sequence_in;
      end
   end

   pcri_stats u_stats (
      .clock           (clock),
      .reset           (reset),
      .step            (advance),
      .frame_length    (in_item_ff.frame_length),
      .second_boundary (in_item_ff.second_boundary),
      .rate_enable     (rate_enable_ff),
      .stats_next      (stats_next)
   );

   // Response register.
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   assign rsp_data_in = {
      {RSP_PAD_W{1'b0}},
      stats_next.rate_bits,
      stats_next.byte_count_high,
      stats_next.byte_count_low,
      gaps_seen_in,
      stats_next.frame_count,
      tail_wide[OFS_FIELD_W-1:0],
      write_wide[OFS_FIELD_W-1:0],
      stored_length,
      entry_flags,
      index_wide[RING_FIELD_W-1:0]
   };

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_state_holds_when_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(buffer_offset_ff) && $stable(ring_position_ff) &&
                   $stable(wrap_count_ff))
      else $error("placement state changed without an item moving on");

   a_wrap_restarts_ring: assert property (@(posedge clock) disable iff (reset)
      advance && wrap |=> buffer_offset_ff == '0 && ring_position_ff == '0)
      else $error("wrap did not return offset and ring index to zero");

   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("evaluated item did not reach the response register");
`endif

endmodule
